### design/ptcirq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcirq_pkg
// Shared sizes, register codes and the command bundle of the prescaled
// timer with compare interrupts.
// ----------------------------------------------------------------------------
package ptcirq_pkg;

    // Sizing
    localparam int HARTS         = 2;
    localparam int COMPARATORS   = 2;
    localparam int PRESCALE_BITS = 12;
    localparam int STEP_BITS     = 8;

    // Bus and counter widths
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 64;
    localparam int STEP_LSB = 16;

    // Transaction kinds
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_IDLE  = 2'd3
    } mode_t;

    // Register map
    typedef enum logic [2:0] {
        REG_CTRL      = 3'd0,
        REG_CFG       = 3'd1,
        REG_COUNT_LO  = 3'd2,
        REG_COUNT_HI  = 3'd3,
        REG_CMP_LO    = 3'd4,
        REG_CMP_HI    = 3'd5,
        REG_IRQ_EN    = 3'd6,
        REG_IRQ_STATE = 3'd7
    } reg_sel_t;

    // Command presented to every hart slice while a transaction is processed
    typedef struct packed {
        logic              go;    // transaction being processed this cycle
        logic              tick;  // clock tick (qualified by go)
        logic              wr;    // register write (qualified by go)
        reg_sel_t          sel;
        logic              cmp;
        logic [DATA_W-1:0] data;
    } cmd_t;

endpackage

### design/prescaled_timer_compare_irq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prescaled_timer_compare_irq
// Per-hart 64-bit machine timer with prescaler and compare interrupts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per cycle
//   while in_ready is high: a clock tick, a 32-bit register read or write,
//   or an idle, with register select, hart and comparator index. Every input
//   transaction yields exactly one output transaction (out_valid/out_ready)
//   carrying read_data (zero unless a read) and irq_lines, the per-hart
//   interrupt requests after that transaction's update.
//   A transaction accepted into the input register is processed when the
//   result register takes it, and its result is offered from then on.
//   Throughput: one transaction per cycle while results are taken, set by
//   the single processing stage between the input register and the result
//   register. A stalled receiver holds the result register; the input
//   register then fills and in_ready drops until the result is taken.
//   Reset clears both stages, all enables, counters and interrupt state;
//   step settings reset to one and compare values to all ones.
// ----------------------------------------------------------------------------
module prescaled_timer_compare_irq (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [2:0]  reg_select,
    input  logic        hart,
    input  logic        comparator,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic [1:0]  irq_lines
);

    localparam int NH = ptcirq_pkg::HARTS;
    localparam int DW = ptcirq_pkg::DATA_W;

    // Input stage
    logic          in_valid_reg;
    logic [1:0]    mode_reg;
    logic [2:0]    reg_select_reg;
    logic          hart_reg;
    logic          comparator_reg;
    logic [DW-1:0] write_data_reg;

    // Result stage
    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] read_data_reg, read_data_next;
    logic [1:0]    irq_lines_reg, irq_lines_next;

    // Global enable
    logic [NH-1:0] enable_reg, enable_next;

    logic                   advance;
    ptcirq_pkg::cmd_t       cmd;
    logic [NH-1:0]          hart_hit;
    logic [NH-1:0][DW-1:0]  hart_rdata;
    logic [NH-1:0]          hart_irq;
    logic [NH:0]            irq_pad;

    // Handshake: process when the result stage is free or being emptied
    assign advance  = in_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid & in_ready)
        begin
            mode_reg       <= mode;
            reg_select_reg <= reg_select;
            hart_reg       <= hart;
            comparator_reg <= comparator;
            write_data_reg <= write_data;
        end
    end

    // Decode
    always_comb
    begin
        cmd.go   = advance;
        cmd.tick = advance & (mode_reg == ptcirq_pkg::MODE_TICK);
        cmd.wr   = advance & (mode_reg == ptcirq_pkg::MODE_WRITE);
        cmd.sel  = ptcirq_pkg::reg_sel_t'(reg_select_reg);
        cmd.cmp  = comparator_reg;
        cmd.data = write_data_reg;
        for (int h = 0; h < NH; h++)
        begin
            hart_hit[h] = (32'(hart_reg) == 32'(h));
        end
    end

    // Hart slices
    for (genvar g = 0; g < NH; g++)
    begin : g_hart
        ptcirq_hart u_hart (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .hit   (hart_hit[g]),
            .run   (enable_reg[g]),
            .rdata (hart_rdata[g]),
            .irq   (hart_irq[g])
        );
    end

    // Global control register, ignores the hart field
    always_comb
    begin
        enable_next = enable_reg;
        if (cmd.wr && cmd.sel == ptcirq_pkg::REG_CTRL)
        begin
            enable_next = write_data_reg[NH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
        end
        else
        begin
            enable_reg <= enable_next;
        end
    end

    // Result assembly
    assign irq_pad = {1'b0, hart_irq};

    always_comb
    begin
        read_data_next = '0;
        if (mode_reg == ptcirq_pkg::MODE_READ)
        begin
            if (cmd.sel == ptcirq_pkg::REG_CTRL)
            begin
                read_data_next = DW'(enable_reg);
            end
            else
            begin
                for (int h = 0; h < NH; h++)
                begin
                    if (hart_hit[h])
                    begin
                        read_data_next = read_data_next | hart_rdata[h];
                    end
                end
            end
        end
        irq_lines_next = irq_pad[1:0];

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_data_reg <= read_data_next;
            irq_lines_reg <= irq_lines_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign irq_lines = irq_lines_reg;

    // Checks
    a_in_stall_only_on_full_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid_reg && !out_ready))
        else $error("input stalled while result stage could drain");

    a_pending_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending transaction lost");

    a_result_from_process: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result appeared without a processed transaction");

    a_non_read_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && mode_reg != ptcirq_pkg::MODE_READ) |=> (read_data_reg == '0))
        else $error("non-read transaction returned data");

    a_ctrl_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.wr && cmd.sel == ptcirq_pkg::REG_CTRL)
            |=> (enable_reg == $past(write_data_reg[NH-1:0])))
        else $error("control write not applied");

endmodule

### design/ptcirq_hart.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcirq_hart
// One hart slice: prescaler, 64-bit counter, compare registers and the
// sticky interrupt state, with its register read path.
// ----------------------------------------------------------------------------
module ptcirq_hart (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ptcirq_pkg::cmd_t              cmd,
    input  logic                          hit,   // this hart is addressed
    input  logic                          run,   // global enable bit
    output logic [ptcirq_pkg::DATA_W-1:0] rdata,
    output logic                          irq
);

    localparam int PB = ptcirq_pkg::PRESCALE_BITS;
    localparam int SB = ptcirq_pkg::STEP_BITS;
    localparam int NC = ptcirq_pkg::COMPARATORS;
    localparam int CW = ptcirq_pkg::COUNT_W;
    localparam int DW = ptcirq_pkg::DATA_W;

    logic [PB-1:0]         presc_set_reg, presc_set_next;
    logic [SB-1:0]         step_set_reg, step_set_next;
    logic [PB-1:0]         presc_cnt_reg, presc_cnt_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [NC-1:0][CW-1:0] cmp_reg, cmp_next;
    logic [NC-1:0]         irq_en_reg, irq_en_next;
    logic [NC-1:0]         irq_st_reg, irq_st_next;

    logic [NC-1:0]         cmp_match;
    logic [NC-1:0]         cmp_hit;
    logic [NC-1:0]         st_clr;
    logic                  wr_go;
    logic                  tick_go;

    // Next-state logic: tick or write, then the compare check
    always_comb
    begin
        wr_go   = cmd.wr & hit;
        tick_go = cmd.tick & run;

        presc_set_next = presc_set_reg;
        step_set_next  = step_set_reg;
        presc_cnt_next = presc_cnt_reg;
        count_next     = count_reg;
        cmp_next       = cmp_reg;
        irq_en_next    = irq_en_reg;
        st_clr         = '0;

        for (int c = 0; c < NC; c++)
        begin
            cmp_match[c] = (32'(cmd.cmp) == 32'(c));
        end

        // prescaler wrap advances the counter by the step
        if (tick_go)
        begin
            if (presc_cnt_reg >= presc_set_reg)
            begin
                presc_cnt_next = '0;
                count_next     = count_reg + CW'(step_set_reg);
            end
            else
            begin
                presc_cnt_next = presc_cnt_reg + PB'(1);
            end
        end

        if (wr_go)
        begin
            case (cmd.sel)
                ptcirq_pkg::REG_CFG:
                begin
                    presc_set_next = cmd.data[PB-1:0];
                    step_set_next  = cmd.data[ptcirq_pkg::STEP_LSB +: SB];
                end
                ptcirq_pkg::REG_COUNT_LO: count_next = {count_reg[CW-1:DW], cmd.data};
                ptcirq_pkg::REG_COUNT_HI: count_next = {cmd.data, count_reg[DW-1:0]};
                ptcirq_pkg::REG_CMP_LO:
                begin
                    for (int c = 0; c < NC; c++)
                    begin
                        if (cmp_match[c])
                        begin
                            cmp_next[c] = {cmp_reg[c][CW-1:DW], cmd.data};
                        end
                    end
                end
                ptcirq_pkg::REG_CMP_HI:
                begin
                    for (int c = 0; c < NC; c++)
                    begin
                        if (cmp_match[c])
                        begin
                            cmp_next[c] = {cmd.data, cmp_reg[c][DW-1:0]};
                        end
                    end
                end
                ptcirq_pkg::REG_IRQ_EN:    irq_en_next = cmd.data[NC-1:0];
                ptcirq_pkg::REG_IRQ_STATE: st_clr      = cmd.data[NC-1:0];
                default: ;
            endcase
        end

        // compare on the updated values; a live match re-sets a cleared bit
        for (int c = 0; c < NC; c++)
        begin
            cmp_hit[c] = (count_next >= cmp_next[c]);
        end
        irq_st_next = cmd.go ? ((irq_st_reg & ~st_clr) | cmp_hit) : irq_st_reg;

        irq = |(irq_st_next & irq_en_next);
    end

    // Register read path, from the state before this transaction
    always_comb
    begin
        rdata = '0;
        case (cmd.sel)
            ptcirq_pkg::REG_CFG:
                rdata = DW'(presc_set_reg) | (DW'(step_set_reg) << ptcirq_pkg::STEP_LSB);
            ptcirq_pkg::REG_COUNT_LO: rdata = count_reg[DW-1:0];
            ptcirq_pkg::REG_COUNT_HI: rdata = count_reg[CW-1:DW];
            ptcirq_pkg::REG_CMP_LO:
            begin
                for (int c = 0; c < NC; c++)
                begin
                    if (cmp_match[c])
                    begin
                        rdata = rdata | cmp_reg[c][DW-1:0];
                    end
                end
            end
            ptcirq_pkg::REG_CMP_HI:
            begin
                for (int c = 0; c < NC; c++)
                begin
                    if (cmp_match[c])
                    begin
                        rdata = rdata | cmp_reg[c][CW-1:DW];
                    end
                end
            end
            ptcirq_pkg::REG_IRQ_EN:    rdata = DW'(irq_en_reg);
            ptcirq_pkg::REG_IRQ_STATE: rdata = DW'(irq_st_reg);
            default:                   rdata = '0;
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presc_set_reg <= '0;
            step_set_reg  <= SB'(1);
            presc_cnt_reg <= '0;
            count_reg     <= '0;
            cmp_reg       <= '1;
            irq_en_reg    <= '0;
            irq_st_reg    <= '0;
        end
        else
        begin
            presc_set_reg <= presc_set_next;
            step_set_reg  <= step_set_next;
            presc_cnt_reg <= presc_cnt_next;
            count_reg     <= count_next;
            cmp_reg       <= cmp_next;
            irq_en_reg    <= irq_en_next;
            irq_st_reg    <= irq_st_next;
        end
    end

endmodule
